FILE: rtl/hpsi_pkg.sv
`timescale 1ns / 1ps

package hpsi_pkg;

	localparam int MAX_RES   = 128;
	localparam int COORD_W   = $clog2(MAX_RES);
	localparam int EXP_W     = 3;
	localparam int INVX_W    = 7;
	localparam int INVY_W    = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int SAMPLE_W  = 32;
	localparam int OUT_W     = 47;
	localparam int TERN_DIG  = 5;
	localparam int REV3_DIG  = 7;
	localparam int POW3_W    = 12;
	localparam int STRIDE_W  = 19;
	localparam int PROD_W    = 20;
	localparam int FULL_W    = SAMPLE_W + STRIDE_W;
	localparam int PIPE_DEPTH = 8;

	localparam logic [CFG_IDX_W-1:0] REG_EXP_BASE2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_BASE3 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_Y = 2'd3;

	typedef struct packed {
		logic [EXP_W-1:0]    e2;
		logic [EXP_W-1:0]    e3;
		logic [INVX_W-1:0]   inv_x;
		logic [INVY_W-1:0]   inv_y;
		logic [POW3_W-1:0]   pow3;
		logic [STRIDE_W-1:0] stride;
	} hpsi_cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] a_lo;
		logic [PROD_W-1:0]  pb;
		logic [OUT_W-1:0]   base;
	} hpsi_mul_t;

	typedef struct packed {
		logic [STRIDE_W-1:0] a_term;
		logic [PROD_W-1:0]   rem;
		logic [OUT_W-1:0]    base;
	} hpsi_red_t;

	typedef struct packed {
		logic [STRIDE_W-1:0] a_term;
		logic [POW3_W-1:0]   rem;
		logic [OUT_W-1:0]    base;
	} hpsi_sum_t;

	function automatic logic [MAX_RES*2*TERN_DIG-1:0] gen_tern();
		logic [MAX_RES*2*TERN_DIG-1:0] t;
		int v;
		t = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			v = i;
			for (int k = 0; k < TERN_DIG; k++) begin
				t[i*2*TERN_DIG + 2*k +: 2] = 2'(v % 3);
				v = v / 3;
			end
		end
		return t;
	endfunction

	// Base-3 digits of every wrapped coordinate, least significant digit first.
	localparam logic [MAX_RES*2*TERN_DIG-1:0] TERN_TAB = gen_tern();

	function automatic logic [POW3_W-1:0] pow3(input logic [EXP_W-1:0] e);
		logic [POW3_W-1:0] p;
		case (e)
			3'd0: p = 12'd1;
			3'd1: p = 12'd3;
			3'd2: p = 12'd9;
			3'd3: p = 12'd27;
			3'd4: p = 12'd81;
			3'd5: p = 12'd243;
			3'd6: p = 12'd729;
			3'd7: p = 12'd2187;
			default: p = 12'd1;
		endcase
		return p;
	endfunction

	function automatic logic [COORD_W-1:0] rev2(input logic [COORD_W-1:0] v,
		input logic [EXP_W-1:0] e);
		logic [COORD_W-1:0] r;
		for (int i = 0; i < COORD_W; i++) begin
			r[i] = v[COORD_W-1-i];
		end
		return COORD_W'(r >> (EXP_W'(COORD_W) - e));
	endfunction

	function automatic logic [POW3_W-1:0] rev3(input logic [COORD_W-1:0] v,
		input logic [EXP_W-1:0] e);
		logic [2*REV3_DIG-1:0] dig;
		logic [POW3_W-1:0]     acc;
		dig = (2*REV3_DIG)'(TERN_TAB[v*2*TERN_DIG +: 2*TERN_DIG]);
		acc = '0;
		for (int i = 0; i < REV3_DIG; i++) begin
			if (EXP_W'(i) < e) begin
				acc = POW3_W'(acc * POW3_W'(3) + POW3_W'(dig[2*i +: 2]));
			end
		end
		return acc;
	endfunction

	function automatic logic [PROD_W-1:0] red_step(input logic [PROD_W-1:0] r,
		input logic [POW3_W-1:0] d, input int k);
		logic [PROD_W-1:0] sub;
		sub = PROD_W'(d) << k;
		return (r >= sub) ? PROD_W'(r - sub) : r;
	endfunction

endpackage

FILE: rtl/hpsi_front.sv
`timescale 1ns / 1ps

module hpsi_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hpsi_pkg::hpsi_cfg_t              cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [hpsi_pkg::COORD_W-1:0]     px,
	input  logic [hpsi_pkg::COORD_W-1:0]     py,
	input  logic [hpsi_pkg::SAMPLE_W-1:0]    smp,
	output logic                             out_valid,
	input  logic                             out_ready,
	output hpsi_pkg::hpsi_mul_t              out_word
);
	import hpsi_pkg::*;

	logic                  v_s1;
	logic [COORD_W-1:0]    dx_s1;
	logic [POW3_W-1:0]     dy_s1;
	logic [SAMPLE_W-1:0]   smp_s1;
	logic                  v_s2;
	hpsi_mul_t             w_s2;
	logic                  rdy_s1;
	logic                  rdy_s2;
	logic [2*COORD_W-1:0]  pa;
	logic [COORD_W-1:0]    mask;
	logic [FULL_W-1:0]     full;

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign pa   = (2*COORD_W)'(dx_s1) * (2*COORD_W)'(cfg.inv_x);
	assign mask = COORD_W'(((COORD_W+1)'(1) << cfg.e2) - (COORD_W+1)'(1));
	assign full = FULL_W'(smp_s1) * FULL_W'(cfg.stride);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dx_s1  <= rev2(px, cfg.e2);
			dy_s1  <= rev3(py, cfg.e3);
			smp_s1 <= smp;
		end
		if (rdy_s2 && v_s1) begin
			w_s2.a_lo <= pa[COORD_W-1:0] & mask;
			w_s2.pb   <= PROD_W'(PROD_W'(dy_s1) * PROD_W'(cfg.inv_y));
			w_s2.base <= full[OUT_W-1:0];
		end
	end

	assign out_valid = v_s2;
	assign out_word  = w_s2;

endmodule

FILE: rtl/hpsi_modred.sv
`timescale 1ns / 1ps

module hpsi_modred (
	input  logic                clk,
	input  logic                arst_n,
	input  hpsi_pkg::hpsi_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  hpsi_pkg::hpsi_mul_t in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output hpsi_pkg::hpsi_sum_t out_word
);
	import hpsi_pkg::*;

	logic      v_s3, v_s4, v_s5, v_s6;
	hpsi_red_t w_s3, w_s4, w_s5, w_s6;
	logic      rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic [POW3_W-1:0] d;

	// Restoring reduction modulo 3^exp_base3, two quotient bits per stage.
	assign d = cfg.pow3;

	assign rdy_s6 = !v_s6 || out_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= in_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			w_s3.a_term <= STRIDE_W'(in_word.a_lo) * STRIDE_W'(d);
			w_s3.rem    <= red_step(red_step(in_word.pb, d, 7), d, 6);
			w_s3.base   <= in_word.base;
		end
		if (rdy_s4 && v_s3) begin
			w_s4.a_term <= w_s3.a_term;
			w_s4.rem    <= red_step(red_step(w_s3.rem, d, 5), d, 4);
			w_s4.base   <= w_s3.base;
		end
		if (rdy_s5 && v_s4) begin
			w_s5.a_term <= w_s4.a_term;
			w_s5.rem    <= red_step(red_step(w_s4.rem, d, 3), d, 2);
			w_s5.base   <= w_s4.base;
		end
		if (rdy_s6 && v_s5) begin
			w_s6.a_term <= w_s5.a_term;
			w_s6.rem    <= red_step(red_step(w_s5.rem, d, 1), d, 0);
			w_s6.base   <= w_s5.base;
		end
	end

	assign out_valid       = v_s6;
	assign out_word.a_term = w_s6.a_term;
	assign out_word.rem    = w_s6.rem[POW3_W-1:0];
	assign out_word.base   = w_s6.base;

endmodule

FILE: rtl/hpsi_back.sv
`timescale 1ns / 1ps

module hpsi_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpsi_pkg::hpsi_cfg_t           cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hpsi_pkg::hpsi_sum_t           in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hpsi_pkg::OUT_W-1:0]    out_index
);
	import hpsi_pkg::*;

	logic                  v_s7;
	logic [OUT_W-1:0]      base_s7;
	logic [STRIDE_W-1:0]   offset_s7;
	logic                  v_s8;
	logic [OUT_W-1:0]      idx_s8;
	logic                  rdy_s7;
	logic                  rdy_s8;
	logic [STRIDE_W:0]     sum;
	logic [STRIDE_W:0]     stride_x;

	assign rdy_s8 = !v_s8 || out_ready;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign in_ready = rdy_s7;

	// Both residue terms lie below the stride, so one subtraction finishes the sum.
	assign sum      = (STRIDE_W+1)'(in_word.a_term)
		+ ((STRIDE_W+1)'(in_word.rem) << cfg.e2);
	assign stride_x = (STRIDE_W+1)'(cfg.stride);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s7) begin
				v_s7 <= in_valid;
			end
			if (rdy_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && in_valid) begin
			base_s7   <= in_word.base;
			offset_s7 <= (sum >= stride_x) ? STRIDE_W'(sum - stride_x) : STRIDE_W'(sum);
		end
		if (rdy_s8 && v_s7) begin
			idx_s8 <= base_s7 + OUT_W'(offset_s7);
		end
	end

	assign out_valid = v_s8;
	assign out_index = idx_s8;

endmodule

FILE: rtl/halton_pixel_sample_index.sv
`timescale 1ns / 1ps
// A request word is registered in each of stages s1 to s8 in turn, and a
// stall can hold it in any of them, before its result word is presented.
// Throughput is one word per cycle while rsp_stall is low, through an
// eight-stage pipeline; the modulo by 3^exp_base3 is a restoring
// reduction spread over four stages. Reset clears all stage valid bits
// and sets the four configuration registers to zero.

module halton_pixel_sample_index (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hpsi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hpsi_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic signed [15:0]                 pixel_x,
	input  logic signed [15:0]                 pixel_y,
	input  logic [hpsi_pkg::SAMPLE_W-1:0]      sample_num,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [hpsi_pkg::OUT_W-1:0]         sample_index
);
	import hpsi_pkg::*;

	logic [EXP_W-1:0]  exp2_q;
	logic [EXP_W-1:0]  exp3_q;
	logic [INVX_W-1:0] invx_q;
	logic [INVY_W-1:0] invy_q;
	hpsi_cfg_t         cfg;
	logic              front_rdy;
	logic              mul_valid, mul_rdy;
	hpsi_mul_t         mul_word;
	logic              red_valid, red_rdy;
	hpsi_sum_t         red_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp2_q <= '0;
			exp3_q <= '0;
			invx_q <= '0;
			invy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXP_BASE2: exp2_q <= cfg_data[EXP_W-1:0];
				REG_EXP_BASE3: exp3_q <= cfg_data[EXP_W-1:0];
				REG_INVERSE_X: invx_q <= cfg_data[INVX_W-1:0];
				REG_INVERSE_Y: invy_q <= cfg_data[INVY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.e2     = exp2_q;
	assign cfg.e3     = exp3_q;
	assign cfg.inv_x  = invx_q;
	assign cfg.inv_y  = invy_q;
	assign cfg.pow3   = pow3(exp3_q);
	assign cfg.stride = STRIDE_W'(pow3(exp3_q)) << exp2_q;

	// The low seven bits are the non-negative residue modulo 128 in two's complement.
	hpsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (req_valid),
		.in_ready  (front_rdy),
		.px        (pixel_x[COORD_W-1:0]),
		.py        (pixel_y[COORD_W-1:0]),
		.smp       (sample_num),
		.out_valid (mul_valid),
		.out_ready (mul_rdy),
		.out_word  (mul_word)
	);

	hpsi_modred u_modred (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (mul_valid),
		.in_ready  (mul_rdy),
		.in_word   (mul_word),
		.out_valid (red_valid),
		.out_ready (red_rdy),
		.out_word  (red_word)
	);

	hpsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (red_valid),
		.in_ready  (red_rdy),
		.in_word   (red_word),
		.out_valid (rsp_valid),
		.out_ready (!rsp_stall),
		.out_index (sample_index)
	);

	assign req_stall = !front_rdy;

endmodule

FILE: rtl/hpsi_checker.sv
`timescale 1ns / 1ps

module hpsi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [hpsi_pkg::OUT_W-1:0]    sample_index
);
	import hpsi_pkg::*;

	localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

	logic [OCC_W-1:0] occ_q;
	logic             take_in;
	logic             take_out;

	assign take_in  = req_valid && !req_stall;
	assign take_out = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= OCC_W'(occ_q + OCC_W'(take_in) - OCC_W'(take_out));
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(sample_index))
		else $error("stalled result word changed or vanished");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	a_valid_backed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occ_q != '0)
		else $error("result word without an accepted request");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q < OCC_W'(PIPE_DEPTH)) || !rsp_stall |-> !req_stall)
		else $error("request stalled while the pipeline has room");

endmodule

bind halton_pixel_sample_index hpsi_checker u_hpsi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.sample_index (sample_index)
);

FILE: dv/tb_halton_pixel_sample_index.sv
`timescale 1ns / 1ps

module tb_halton_pixel_sample_index;
	import hpsi_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0]       x;
		logic [15:0]       y;
		logic [SAMPLE_W-1:0] s;
		logic [OUT_W-1:0]  unit_idx;
	} pixel_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	logic signed [15:0]   pixel_x;
	logic signed [15:0]   pixel_y;
	logic [SAMPLE_W-1:0]  sample_num;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [OUT_W-1:0]     sample_index;

	logic                 row_typed;
	logic [OUT_W-1:0]     row_index;

	logic [EXP_W-1:0]     e2_shadow;
	logic [EXP_W-1:0]     e3_shadow;
	logic [INVX_W-1:0]    invx_shadow;
	logic [INVY_W-1:0]    invy_shadow;

	logic [OUT_W-1:0]     pending_index[$];
	int                   mismatches;
	int                   words_in;
	int                   cycles;
	int                   burst_left;

	pixel_row_t corner_rows[12] = '{
		'{16'h0000, 16'h0000, 32'h00000000, 47'h0},
		'{16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 47'hFFFFFFFF},
		'{16'h8000, 16'h8000, 32'h00000001, 47'h1},
		'{16'hFFFF, 16'hFFFF, 32'h00000002, 47'h2},
		'{16'h007F, 16'h0000, 32'h00000003, 47'h3},
		'{16'h0000, 16'h007F, 32'h80000000, 47'h80000000},
		'{16'h0080, 16'h0080, 32'h00000005, 47'h5},
		'{16'hFF81, 16'h0051, 32'h7FFFFFFF, 47'h7FFFFFFF},
		'{16'h0055, 16'h002A, 32'hAAAAAAAA, 47'hAAAAAAAA},
		'{16'h002A, 16'h0055, 32'h55555555, 47'h55555555},
		'{16'hFFC0, 16'h0079, 32'hFFFFFFFE, 47'hFFFFFFFE},
		'{16'h0001, 16'h0002, 32'h0000FFFF, 47'hFFFF}
	};

	halton_pixel_sample_index uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.sample_num(sample_num),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sample_index(sample_index)
	);

	always #5 clk = ~clk;

	function automatic logic [OUT_W-1:0] halton_index(logic [15:0] x, logic [15:0] y,
		logic [SAMPLE_W-1:0] s);
		longint unsigned px, py, dx, dy, scale2, scale3, stride, offset;
		px = longint'(x) % MAX_RES;
		py = longint'(y) % MAX_RES;
		scale2 = 1;
		scale3 = 1;
		dx = 0;
		dy = 0;
		for (int i = 0; i < e2_shadow; i++) begin
			scale2 = scale2 * 2;
			dx = dx * 2 + px % 2;
			px = px / 2;
		end
		for (int i = 0; i < e3_shadow; i++) begin
			scale3 = scale3 * 3;
			dy = dy * 3 + py % 3;
			py = py / 3;
		end
		stride = scale2 * scale3;
		offset = (dx * scale3 * invx_shadow + dy * scale2 * invy_shadow) % stride;
		return OUT_W'(offset + longint'(s) * stride);
	endfunction

	function automatic int mod_inverse(int a, int m);
		for (int k = 0; k < m; k++) begin
			if ((a * k) % m == 1) begin
				return k;
			end
		end
		return 0;
	endfunction

	// Accepted words and config writes are seen here, so the expectations
	// follow the port activity rather than the stimulus code.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_index.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected sample_index %h", sample_index);
					end
				end else begin
					if (sample_index !== pending_index[0]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("sample_index mismatch: expected %h, got %h",
								pending_index[0], sample_index);
						end
					end
					void'(pending_index.pop_front());
				end
			end
			if (req_valid && !req_stall) begin
				words_in++;
				if (row_typed) begin
					pending_index.push_back(row_index);
				end else begin
					pending_index.push_back(halton_index(pixel_x, pixel_y, sample_num));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_EXP_BASE2: e2_shadow <= cfg_data[EXP_W-1:0];
					REG_EXP_BASE3: e3_shadow <= cfg_data[EXP_W-1:0];
					REG_INVERSE_X: invx_shadow <= cfg_data[INVX_W-1:0];
					REG_INVERSE_Y: invy_shadow <= cfg_data[INVY_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: stall mode changes per segment; one long hold-off fills the pipeline.
	initial begin
		int seg_left;
		int mode;
		int hold_left;
		bit held;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (!held && words_in >= 300) begin
				held = 1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(5, 60);
					mode = $urandom_range(0, 3);
				end
				seg_left--;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
	endtask

	task automatic set_config(int e2, int e3, int inv_x, int inv_y);
		@(posedge clk);
		while (pending_index.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
		write_reg(REG_EXP_BASE2, e2);
		write_reg(REG_EXP_BASE3, e3);
		write_reg(REG_INVERSE_X, inv_x);
		write_reg(REG_INVERSE_Y, inv_y);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic matched_config(int e2, int e3);
		int scale2;
		int scale3;
		scale2 = 1 << e2;
		scale3 = 1;
		for (int i = 0; i < e3; i++) begin
			scale3 = scale3 * 3;
		end
		set_config(e2, e3, mod_inverse(scale3 % scale2, scale2) & 8'h7F,
			mod_inverse(scale2 % scale3, scale3) & 8'hFF);
	endtask

	task automatic send_word(logic [15:0] x, logic [15:0] y, logic [SAMPLE_W-1:0] s,
		logic typed, logic [OUT_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		sample_num <= s;
		row_typed <= typed;
		row_index <= idx;
		do begin
			@(posedge clk);
		end while (req_stall);
		burst_left--;
	endtask

	task automatic end_burst();
		req_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic run_corners(logic typed);
		foreach (corner_rows[i]) begin
			send_word(corner_rows[i].x, corner_rows[i].y, corner_rows[i].s, typed,
				corner_rows[i].unit_idx);
		end
		end_burst();
	endtask

	task automatic run_random(int count);
		logic [SAMPLE_W-1:0] s;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 7);
			if (pick == 0) begin
				s = '1;
			end else if (pick == 1) begin
				s = '0;
			end else begin
				s = $urandom;
			end
			send_word(16'($urandom), 16'($urandom), s, 1'b0, '0);
		end
		end_burst();
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_valid <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		sample_num <= '0;
		rsp_stall <= 1'b0;
		row_typed <= 1'b0;
		row_index <= '0;
		e2_shadow = '0;
		e3_shadow = '0;
		invx_shadow = '0;
		invy_shadow = '0;
		mismatches = 0;
		words_in = 0;
		cycles = 0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_corners(1'b1);
		run_random(150);
		matched_config(7, 5);
		run_corners(1'b0);
		run_random(250);
		set_config(7, 7, 127, 255);
		run_random(150);
		matched_config(0, 5);
		run_random(150);
		matched_config(7, 0);
		run_random(150);
		set_config(3, 2, 127, 255);
		run_random(150);
		for (int p = 0; p < 4; p++) begin
			if ($urandom_range(0, 1) == 0) begin
				matched_config($urandom_range(0, 7), $urandom_range(0, 5));
			end else begin
				set_config($urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 127), $urandom_range(0, 255));
			end
			run_random(125);
		end

		@(posedge clk);
		while (pending_index.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_index.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/hpsi_pkg.sv
rtl/hpsi_front.sv
rtl/hpsi_modred.sv
rtl/hpsi_back.sv
rtl/halton_pixel_sample_index.sv
rtl/hpsi_checker.sv
dv/tb_halton_pixel_sample_index.sv
